// ----- rtl/core/fwpr_pkg.sv -----
// Package for the fixed-weight pattern ranker: widths, register map,
// shared state types and bit helpers. No dependencies.
`default_nettype none

package fwpr_pkg;

  localparam int unsigned MAX_BITS = 32;
  localparam int unsigned PAT_W    = MAX_BITS;
  localparam int unsigned WGT_W    = $clog2(MAX_BITS + 1);
  localparam int unsigned RANK_W   = 30;
  localparam int unsigned NBITS_W  = 6;
  localparam int unsigned DATA_W   = 32;

  // Register map: one word per register.
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_NBITS = REG_IDX_W'(0);

  localparam logic [NBITS_W-1:0] NBITS_RESET = NBITS_W'(16);

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [WGT_W-1:0]  weight;
    logic [RANK_W-1:0] rank;
  } walk_t;

  typedef struct packed {
    logic last_weight;
    logic last_table;
  } flags_t;

  // Mask with the k lowest bits set, saturating at the full pattern width.
  function automatic logic [PAT_W-1:0] low_ones(input logic [WGT_W-1:0] k);
    logic [PAT_W:0] m;
    m = ((PAT_W+1)'(1) << k) - (PAT_W+1)'(1);
    if (k >= WGT_W'(MAX_BITS)) begin
      low_ones = '1;
    end else begin
      low_ones = m[PAT_W-1:0];
    end
  endfunction

  // Clamp the programmed width into 1..MAX_BITS.
  function automatic logic [WGT_W-1:0] eff_width(input logic [NBITS_W-1:0] nb);
    if (nb == '0) begin
      eff_width = WGT_W'(1);
    end else if (nb > NBITS_W'(MAX_BITS)) begin
      eff_width = WGT_W'(MAX_BITS);
    end else begin
      eff_width = WGT_W'(nb);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fwpr_flags.sv -----
// End-of-weight and end-of-table detection for one walk state.
// Depends on fwpr_pkg.
`default_nettype none

module fwpr_flags import fwpr_pkg::*; (
  input  walk_t            walk_i,
  input  logic [WGT_W-1:0] width_i,
  output flags_t           flags_o
);

  logic [WGT_W-1:0] free_bits;
  logic [PAT_W-1:0] top_pat;

  // Highest pattern of this weight: ones packed against the top of the width.
  assign free_bits = width_i - walk_i.weight;
  assign top_pat   = low_ones(width_i) & ~low_ones(free_bits);

  assign flags_o.last_table  = (walk_i.weight >= width_i);
  assign flags_o.last_weight = flags_o.last_table || (walk_i.pattern >= top_pat);

endmodule

`default_nettype wire

// ----- rtl/core/fwpr_next.sv -----
// Next-entry logic: restart, weight step and the next-combination step.
// Depends on fwpr_pkg.
`default_nettype none

module fwpr_next import fwpr_pkg::*; (
  input  walk_t walk_i,
  input  flags_t flags_i,
  input  logic  restart_i,
  input  logic  started_i,
  output walk_t walk_o
);

  logic [PAT_W:0]   p_ext;
  logic [PAT_W:0]   t_ext;
  logic [PAT_W:0]   fill;
  logic [WGT_W-1:0] tz_p;
  logic [WGT_W-1:0] tz_t;
  logic [WGT_W-1:0] shift_d;
  logic [WGT_W-1:0] wgt_inc;

  // Trailing-zero count over the extended word.
  function automatic logic [WGT_W-1:0] ctz(input logic [PAT_W:0] v);
    logic [WGT_W-1:0] c;
    c = WGT_W'(PAT_W + 1);
    for (int i = PAT_W; i >= 0; i--) begin
      if (v[i]) begin
        c = WGT_W'(i);
      end
    end
    return c;
  endfunction

  // Clear the lowest run of ones and carry into the next bit, then refill
  // the bottom with one fewer ones than the run held.
  assign p_ext   = {1'b0, walk_i.pattern};
  assign t_ext   = (p_ext | (p_ext - (PAT_W+1)'(1))) + (PAT_W+1)'(1);
  assign tz_p    = ctz(p_ext);
  assign tz_t    = ctz(t_ext);
  assign shift_d = tz_t - tz_p;
  assign fill    = (((PAT_W+1)'(1) << shift_d) >> 1) - (PAT_W+1)'(1);
  assign wgt_inc = walk_i.weight + WGT_W'(1);

  always_comb begin
    walk_o = walk_i;
    if (restart_i) begin
      walk_o.pattern = '0;
      walk_o.weight  = '0;
      walk_o.rank    = RANK_W'(1);
    end else if (!started_i) begin
      walk_o = walk_i;
    end else if (flags_i.last_table) begin
      walk_o.pattern = '0;
      walk_o.weight  = '0;
      walk_o.rank    = RANK_W'(1);
    end else if (flags_i.last_weight) begin
      walk_o.weight  = wgt_inc;
      walk_o.pattern = low_ones(wgt_inc);
      walk_o.rank    = RANK_W'(1);
    end else begin
      walk_o.pattern = t_ext[PAT_W-1:0] | fill[PAT_W-1:0];
      walk_o.rank    = walk_i.rank + RANK_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fixed_weight_pattern_ranker.sv -----
// Fixed-weight pattern ranker: walks all patterns of n_bits bits by rising
// weight, one entry per item. Entries pass the walk state and then the result
// register. Throughput: one item per cycle unless output stalls; the former
// closes the only loop (next-entry logic), the latter parts it from the output.
// Reset: n_bits = 16, walk at weight zero, rank 1; first plain item emits it.
`default_nettype none

module fixed_weight_pattern_ranker import fwpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PAT_W-1:0]   pattern_o,
  output logic [WGT_W-1:0]   weight_o,
  output logic [RANK_W-1:0]  rank_o,
  output logic               last_of_weight_o,
  output logic               last_of_table_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [NBITS_W-1:0] nbits_q;
  logic [WGT_W-1:0]   width;
  logic               cfg_wr;

  walk_t  walk_q;
  walk_t  walk_d;
  flags_t flags;
  logic   started_q;
  logic   s1_vld_q;
  logic   s1_adv;
  logic   in_acc;

  logic               out_vld_q;
  logic [PAT_W-1:0]   out_pat_q;
  logic [WGT_W-1:0]   out_wgt_q;
  logic [RANK_W-1:0]  out_rank_q;
  logic               out_lw_q;
  logic               out_lt_q;

  // ---------------------------------------------------------------------------
  // Configuration: single width register, always ready.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_NBITS) ? DATA_W'(nbits_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbits_q <= NBITS_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_NBITS)) begin
      nbits_q <= pwdata[NBITS_W-1:0];
    end
  end

  assign width = eff_width(nbits_q);

  // ---------------------------------------------------------------------------
  // Handshake. The walk register doubles as the first stage: it holds the
  // entry of the latest item until it moves into the result register. Stall
  // the input only when that entry cannot move on.
  // ---------------------------------------------------------------------------
  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Flags of the held entry: steer the next step and go out with the result.
  fwpr_flags u_flags (
    .walk_i  (walk_q),
    .width_i (width),
    .flags_o (flags)
  );

  fwpr_next u_next (
    .walk_i    (walk_q),
    .flags_i   (flags),
    .restart_i (restart_i),
    .started_i (started_q),
    .walk_o    (walk_d)
  );

  // Load the next walk state on every accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q.pattern <= '0;
      walk_q.weight  <= '0;
      walk_q.rank    <= RANK_W'(1);
      started_q      <= 1'b0;
      s1_vld_q       <= 1'b0;
    end else begin
      if (in_acc) begin
        walk_q    <= walk_d;
        started_q <= 1'b1;
      end
      s1_vld_q <= in_acc || (s1_vld_q && !s1_adv);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load when the held entry advances, drop when taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= s1_adv || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pat_q  <= walk_q.pattern;
      out_wgt_q  <= walk_q.weight;
      out_rank_q <= walk_q.rank;
      out_lw_q   <= flags.last_weight;
      out_lt_q   <= flags.last_table;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pattern_o        = out_pat_q;
  assign weight_o         = out_wgt_q;
  assign rank_o           = out_rank_q;
  assign last_of_weight_o = out_lw_q;
  assign last_of_table_o  = out_lt_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The weight always matches the pattern's popcount.
  a_weight_popcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(walk_q.pattern) == 32'(walk_q.weight))
    else $error("walk weight does not match pattern popcount");

  // A restart lands on the weight-zero entry with rank 1.
  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && restart_i |=> walk_q.pattern == '0 && walk_q.weight == '0 &&
                            walk_q.rank == RANK_W'(1))
    else $error("restart did not return to weight zero");

  // An accepted item always occupies the first stage next cycle.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("accepted item lost before the result register");

  // The last table entry is also the last of its weight.
  a_flags_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !out_lt_q || out_lw_q)
    else $error("last of table without last of weight");

endmodule

`default_nettype wire

// ----- tb/fwpr_ranker_checker.sv -----
// Result checker for the fixed-weight pattern ranker: tracks the width register
// from the configuration port and predicts every table entry. Uses fwpr_pkg.
`timescale 1ns / 100ps

module fwpr_ranker_checker import fwpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               restart_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [PAT_W-1:0]   pattern_i,
  input  logic [WGT_W-1:0]   weight_i,
  input  logic [RANK_W-1:0]  rank_i,
  input  logic               last_of_weight_i,
  input  logic               last_of_table_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0]  pwdata_i,
  input  logic               pready_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    walk_t  walk;
    flags_t flags;
  } entry_t;

  logic [NBITS_W-1:0] width_reg = NBITS_RESET;
  walk_t              walk_pos;
  logic               walk_started = 1'b0;
  entry_t             entry_q[$];

  initial begin
    walk_pos.pattern = '0;
    walk_pos.weight  = '0;
    walk_pos.rank    = RANK_W'(1);
    error_count_o    = 0;
    pending_o        = 0;
  end

  function automatic logic [63:0] ones_below(input int unsigned k);
    if (k >= 32) begin
      return 64'hFFFF_FFFF;
    end
    return (64'd1 << k) - 64'd1;
  endfunction

  function automatic int unsigned clamp_width(input logic [NBITS_W-1:0] nb);
    if (nb == '0) begin
      return 1;
    end else if (nb > MAX_BITS) begin
      return MAX_BITS;
    end
    return nb;
  endfunction

  function automatic int unsigned trailing_zeros(input logic [63:0] v);
    int unsigned c;
    c = 0;
    while (c < 63 && !v[c]) c++;
    return c;
  endfunction

  // A weight at or past the width ends the table; a pattern at or past the
  // top pattern of its weight ends that weight.
  function automatic flags_t entry_flags(input walk_t w, input int unsigned n);
    flags_t f;
    f.last_table = (w.weight >= n);
    if (f.last_table) begin
      f.last_weight = 1'b1;
    end else begin
      f.last_weight = (64'(w.pattern) >= (ones_below(n) & ~ones_below(n - w.weight)));
    end
    return f;
  endfunction

  function automatic walk_t next_entry(input walk_t w, input int unsigned n);
    walk_t       nxt;
    flags_t      f;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] fill;
    int unsigned d;
    f   = entry_flags(w, n);
    nxt = w;
    if (f.last_table) begin
      nxt.pattern = '0;
      nxt.weight  = '0;
      nxt.rank    = RANK_W'(1);
    end else if (f.last_weight) begin
      nxt.weight  = w.weight + 1'b1;
      nxt.pattern = PAT_W'(ones_below(nxt.weight));
      nxt.rank    = RANK_W'(1);
    end else begin
      // next combination of the same weight: carry the lowest run up, refill low bits
      p           = 64'(w.pattern);
      t           = (p | (p - 64'd1)) + 64'd1;
      d           = trailing_zeros(t) - trailing_zeros(p);
      fill        = ((64'd1 << d) >> 1) - 64'd1;
      nxt.pattern = PAT_W'(t | fill);
      nxt.rank    = w.rank + 1'b1;
    end
    return nxt;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t      want;
    int unsigned n;
    if (!rst_ni) begin
      width_reg        = NBITS_RESET;
      walk_pos.pattern = '0;
      walk_pos.weight  = '0;
      walk_pos.rank    = RANK_W'(1);
      walk_started     = 1'b0;
      entry_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[PADDR_W-1:2] == REG_NBITS) begin
        width_reg = pwdata_i[NBITS_W-1:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (entry_q.size() == 0) begin
          $display("%0t: unexpected item: pattern %0h weight %0d rank %0d",
                   $time, pattern_i, weight_i, rank_i);
          error_count_o++;
        end else begin
          want = entry_q.pop_front();
          check_field("pattern", want.walk.pattern, pattern_i);
          check_field("weight", want.walk.weight, weight_i);
          check_field("rank", want.walk.rank, rank_i);
          check_field("last_of_weight", want.flags.last_weight, last_of_weight_i);
          check_field("last_of_table", want.flags.last_table, last_of_table_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        n = clamp_width(width_reg);
        if (restart_i) begin
          walk_pos.pattern = '0;
          walk_pos.weight  = '0;
          walk_pos.rank    = RANK_W'(1);
        end else if (walk_started) begin
          walk_pos = next_entry(walk_pos, n);
        end
        walk_started = 1'b1;
        want.walk    = walk_pos;
        want.flags   = entry_flags(walk_pos, n);
        entry_q.push_back(want);
      end
    end
    pending_o = entry_q.size();
  end

endmodule

// ----- tb/fixed_weight_pattern_ranker_tb.sv -----
// Top of the fixed-weight pattern ranker testbench: clock, reset, request and
// configuration stimulus, verdict. Needs fwpr_pkg, the ranker and its checker.
`timescale 1ns / 100ps

module fixed_weight_pattern_ranker_tb;
  import fwpr_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HOLD_CYCLES = 300;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               restart  = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PAT_W-1:0]   pattern;
  logic [WGT_W-1:0]   weight;
  logic [RANK_W-1:0]  rank;
  logic               last_of_weight;
  logic               last_of_table;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0]  pwdata   = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned error_count;
  int unsigned pending;

  // Idle and stall odds in percent, set per phase by the main sequence.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned phase_no      = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  bit          want_hold     = 1'b0;

  always #2 clk = ~clk;

  fixed_weight_pattern_ranker uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .pattern_o        (pattern),
    .weight_o         (weight),
    .rank_o           (rank),
    .last_of_weight_o (last_of_weight),
    .last_of_table_o  (last_of_table),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  fwpr_ranker_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .restart_i        (restart),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pattern_i        (pattern),
    .weight_i         (weight),
    .rank_i           (rank),
    .last_of_weight_i (last_of_weight),
    .last_of_table_i  (last_of_table),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .error_count_o    (error_count),
    .pending_o        (pending)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the block fills up and pushes back on the request channel.
  always @(negedge clk) begin
    if (want_hold) begin
      hold_left = HOLD_CYCLES;
      want_hold = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one request item and hold it until the block takes it. Valid stays
  // high into the next item unless the sender chooses to idle.
  task automatic send_item(input logic restart_req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_req;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted entry has come out, then let the
  // result pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the width register; random upper data bits must be ignored.
  task automatic write_width(input logic [NBITS_W-1:0] nb);
    logic [DATA_W-1:0] word;
    word                = $urandom;
    word[NBITS_W-1:0]   = nb;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NBITS, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random phase: new width without restarting the walk (so widths change
  // mid-walk), then mostly plain advance requests with rare restarts.
  task automatic run_phase(input logic [NBITS_W-1:0] nb, input int unsigned count,
                           input int unsigned restart_pct, input bit lead_restart,
                           input bit hold);
    wait_idle();
    write_width(nb);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 82; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 82; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
    // the hold-off needs a sender that keeps offering items
    if (hold) send_idle_pct = 0;
    phase_no++;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold && i == 2) want_hold = 1'b1;
      send_item((lead_restart && i == 0) || ($urandom_range(99) < restart_pct));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset width of 16; first plain request emits weight zero
    // without advancing, then advance twice, restart, advance again.
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // Width zero acts as one: the table is just 0 and 1, wrapping.
    wait_idle();
    write_width(NBITS_W'(0));
    repeat (4) send_item(1'b0);

    // Width above the maximum acts as the maximum.
    wait_idle();
    write_width(NBITS_W'(63));
    send_item(1'b1);
    repeat (3) send_item(1'b0);

    // Small width mid-walk: whole table, last-of-weight and wrap to zero.
    wait_idle();
    write_width(NBITS_W'(3));
    repeat (10) send_item(1'b0);

    // Random phases over widths from tiny to full and beyond.
    run_phase(NBITS_W'(5),  80,  2, 1'b0, 1'b0);
    run_phase(NBITS_W'(32), 120, 0, 1'b1, 1'b0);
    run_phase(NBITS_W'(8),  80,  3, 1'b0, 1'b1);
    run_phase(NBITS_W'(2),  60,  5, 1'b0, 1'b0);
    run_phase(NBITS_W'(63), 80,  1, 1'b0, 1'b0);
    run_phase(NBITS_W'(12), 80,  2, 1'b0, 1'b0);
    run_phase(NBITS_W'(0),  40, 10, 1'b0, 1'b0);
    run_phase(NBITS_W'(16), 80,  3, 1'b0, 1'b0);
    run_phase(NBITS_W'(3),  60,  5, 1'b0, 1'b0);
    run_phase(NBITS_W'(33), 80,  2, 1'b0, 1'b0);
    run_phase(NBITS_W'(7),  80,  2, 1'b0, 1'b1);
    run_phase(NBITS_W'(1),  40, 10, 1'b0, 1'b0);
    run_phase(NBITS_W'(10), 80,  2, 1'b0, 1'b0);

    // Drain the last results, then give the verdict.
    wait_idle();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
